// File: design/assert_macros.svh
// Assertion helpers shared by the RTL. Both macros fall away in synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check a property on every rising edge outside reset.
`define ASSERT_PROP(lbl, clk_s, rst_s, prop) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (prop)) \
    else $error("%m: property failed");

// Check that a condition never holds outside reset.
`define ASSERT_NEVER(lbl, clk_s, rst_s, cond) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) !(cond)) \
    else $error("%m: forbidden condition seen");

`else

`define ASSERT_PROP(lbl, clk_s, rst_s, prop)
`define ASSERT_NEVER(lbl, clk_s, rst_s, cond)

`endif

`endif

// File: design/iqci_pkg.sv
`timescale 1ns / 1ps
package iqci_pkg;

  localparam int NUM_POINTS_DEF = 5;
  localparam int FRAC_BITS_DEF  = 20;
  localparam int NUM_PARAMS     = 6;
  localparam int MAX_POINTS     = 5;
  // Integer bits kept by the divider; a larger quotient saturates that parameter's result.
  localparam int INT_BITS       = 26;

  localparam int OUT_W   = 24;
  localparam int OUT_MAX = 8388607;
  localparam int OUT_MIN = -8388608;

  localparam logic [31:0] FREQ_RESET [MAX_POINTS] = '{
    32'd3600000, 32'd14100000, 32'd21100000, 32'd28100000, 32'd29650000
  };
  localparam logic [15:0] SCALE_RESET = 16'd1024;

  // Configuration register indexes
  localparam logic [2:0] REG_PHASE_SCALE = 3'd5;
  localparam logic [2:0] REG_GAIN_SCALE  = 3'd6;

  // Request operation codes
  localparam logic OPER_WRITE = 1'b0;
  localparam logic OPER_QUERY = 1'b1;

  // Parameter codes
  localparam logic [2:0] PAR_RX_GAIN      = 3'd0;
  localparam logic [2:0] PAR_RX_PHASE     = 3'd1;
  localparam logic [2:0] PAR_TX_ON_GAIN   = 3'd2;
  localparam logic [2:0] PAR_TX_OFF_GAIN  = 3'd3;
  localparam logic [2:0] PAR_TX_ON_PHASE  = 3'd4;
  localparam logic [2:0] PAR_TX_OFF_PHASE = 3'd5;

  // Datapath commands
  localparam logic [3:0] OP_NONE   = 4'd0;
  localparam logic [3:0] OP_WRITE  = 4'd1;
  localparam logic [3:0] OP_LOAD   = 4'd2;
  localparam logic [3:0] OP_SEARCH = 4'd3;
  localparam logic [3:0] OP_RD_LO  = 4'd4;
  localparam logic [3:0] OP_RD_HI  = 4'd5;
  localparam logic [3:0] OP_MUL_A  = 4'd6;
  localparam logic [3:0] OP_MUL_B  = 4'd7;
  localparam logic [3:0] OP_MUL_C  = 4'd8;
  localparam logic [3:0] OP_MUL_D  = 4'd9;
  localparam logic [3:0] OP_SUM    = 4'd10;
  localparam logic [3:0] OP_PREP   = 4'd11;
  localparam logic [3:0] OP_DIV    = 4'd12;
  localparam logic [3:0] OP_STORE  = 4'd13;
  localparam logic [3:0] OP_EMIT   = 4'd14;

  typedef struct packed {
    logic [3:0] op;
    logic [2:0] param;
  } cmd_t;

  typedef struct packed {
    logic out_full;
  } stat_t;

endpackage

// File: design/iqci_ctrl.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module iqci_ctrl import iqci_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  logic  operation,
  input  stat_t stat,
  output cmd_t  cmd
);

  localparam int QW = INT_BITS + FRAC_BITS;
  localparam int CW = $clog2(QW);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_SEARCH = 4'd1;
  localparam logic [3:0] S_RD_LO  = 4'd2;
  localparam logic [3:0] S_RD_HI  = 4'd3;
  localparam logic [3:0] S_MUL_A  = 4'd4;
  localparam logic [3:0] S_MUL_B  = 4'd5;
  localparam logic [3:0] S_MUL_C  = 4'd6;
  localparam logic [3:0] S_MUL_D  = 4'd7;
  localparam logic [3:0] S_SUM    = 4'd8;
  localparam logic [3:0] S_PREP   = 4'd9;
  localparam logic [3:0] S_DIV    = 4'd10;
  localparam logic [3:0] S_STORE  = 4'd11;
  localparam logic [3:0] S_DONE   = 4'd12;

  logic [3:0]    state, state_next;
  logic [2:0]    param, param_next;
  logic [CW-1:0] cnt, cnt_next;

  assign in_ready  = (state == S_IDLE);
  assign cmd.param = param;

  always_comb begin
    state_next = state;
    param_next = param;
    cnt_next   = cnt;
    cmd.op     = OP_NONE;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (operation == OPER_WRITE) begin
            cmd.op = OP_WRITE;
          end else begin
            cmd.op     = OP_LOAD;
            param_next = '0;
            state_next = S_SEARCH;
          end
        end
      end
      S_SEARCH: begin
        cmd.op     = OP_SEARCH;
        state_next = S_RD_LO;
      end
      S_RD_LO: begin
        cmd.op     = OP_RD_LO;
        state_next = S_RD_HI;
      end
      S_RD_HI: begin
        cmd.op     = OP_RD_HI;
        state_next = S_MUL_A;
      end
      S_MUL_A: begin
        cmd.op     = OP_MUL_A;
        state_next = S_MUL_B;
      end
      S_MUL_B: begin
        cmd.op     = OP_MUL_B;
        state_next = S_MUL_C;
      end
      S_MUL_C: begin
        cmd.op     = OP_MUL_C;
        state_next = S_MUL_D;
      end
      S_MUL_D: begin
        cmd.op     = OP_MUL_D;
        state_next = S_SUM;
      end
      S_SUM: begin
        cmd.op     = OP_SUM;
        state_next = S_PREP;
      end
      S_PREP: begin
        cmd.op     = OP_PREP;
        cnt_next   = '0;
        state_next = S_DIV;
      end
      S_DIV: begin
        cmd.op   = OP_DIV;
        cnt_next = cnt + 1'b1;
        if (cnt == CW'(QW - 1)) begin
          state_next = S_STORE;
        end
      end
      S_STORE: begin
        cmd.op = OP_STORE;
        if (param == 3'(NUM_PARAMS - 1)) begin
          state_next = S_DONE;
        end else begin
          param_next = param + 1'b1;
          state_next = S_SEARCH;
        end
      end
      S_DONE: begin
        // hold until the output register is free
        if (!stat.out_full) begin
          cmd.op     = OP_EMIT;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      param <= '0;
      cnt   <= '0;
    end else begin
      state <= state_next;
      param <= param_next;
      cnt   <= cnt_next;
    end
  end

  `ASSERT_NEVER(a_param_range, clk, rst, param > 3'(NUM_PARAMS - 1))
  `ASSERT_PROP(a_first_search, clk, rst,
    (state == S_SEARCH && param == 3'd0) |-> $past(state == S_IDLE))
  `ASSERT_PROP(a_emit_free, clk, rst, (cmd.op == OP_EMIT) |-> !stat.out_full)

endmodule

// File: design/iqci_datapath.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module iqci_datapath import iqci_pkg::*; #(
  parameter int NUM_POINTS = NUM_POINTS_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  cmd_t                    cmd,
  output stat_t                   stat,
  input  logic                    cfg_valid,
  input  logic [2:0]              cfg_index,
  input  logic [31:0]             cfg_data,
  input  logic [2:0]              param_select,
  input  logic [2:0]              point_index,
  input  logic signed [15:0]      cal_value,
  input  logic                    mark_unset,
  input  logic [31:0]             query_freq,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [OUT_W-1:0] rx_phase_adj,
  output logic signed [OUT_W-1:0] rx_gain_i,
  output logic signed [OUT_W-1:0] rx_gain_q,
  output logic signed [OUT_W-1:0] tx_on_phase_adj,
  output logic signed [OUT_W-1:0] tx_off_phase_adj,
  output logic signed [OUT_W-1:0] tx_on_gain_i,
  output logic signed [OUT_W-1:0] tx_on_gain_q,
  output logic signed [OUT_W-1:0] tx_off_gain_i,
  output logic signed [OUT_W-1:0] tx_off_gain_q
);

  localparam int ENTRIES = NUM_PARAMS * NUM_POINTS;
  localparam int ENT_W   = $clog2(ENTRIES);
  localparam int PT_W    = (NUM_POINTS > 1) ? $clog2(NUM_POINTS) : 1;
  localparam int QW      = INT_BITS + FRAC_BITS;
  localparam int VW      = QW + 1;
  localparam int SW      = VW + 1;
  localparam int NW      = 51;
  localparam int MW      = 48;

  localparam logic signed [SW-1:0] ONE     = SW'(1) << FRAC_BITS;
  localparam logic signed [SW-1:0] SAT_MAX = SW'(OUT_MAX);
  localparam logic signed [SW-1:0] SAT_MIN = SW'(OUT_MIN);

  function automatic logic signed [OUT_W-1:0] sat24(input logic signed [SW-1:0] x);
    logic signed [OUT_W-1:0] r;
    if (x > SAT_MAX) begin
      r = OUT_W'(OUT_MAX);
    end else if (x < SAT_MIN) begin
      r = OUT_W'(OUT_MIN);
    end else begin
      r = x[OUT_W-1:0];
    end
    return r;
  endfunction

  // Configuration and table
  logic [31:0]        freq_r [NUM_POINTS];
  logic [15:0]        phase_scale;
  logic [15:0]        gain_scale;
  logic signed [15:0] table_val [ENTRIES];
  logic               table_vld [ENTRIES];

  // Working registers
  logic [31:0]           qf;
  logic [PT_W-1:0]       lo, hi;
  logic                  none;
  logic signed [15:0]    al, ah;
  logic [31:0]           fl, fh;
  logic signed [32:0]    dd, dfl;
  logic signed [48:0]    p1;
  logic signed [49:0]    p2;
  logic [MW-1:0]         mden;
  logic signed [NW-1:0]  n_r;
  logic [MW-1:0]         rem;
  logic [QW-1:0]         sh, quo;
  logic                  big, neg;
  logic signed [VW-1:0]  v [NUM_PARAMS];

  // Search results
  logic            have1, have2, hit, pv_ok, vb;
  logic [PT_W-1:0] h, pv, sv, lv, slv;
  logic [PT_W-1:0] lo_sel, hi_sel;

  logic [ENT_W-1:0]     e_w, e_rd;
  logic [PT_W-1:0]      pt_rd;
  logic signed [16:0]   diff;
  logic [15:0]          sc_raw, sc;
  logic signed [32:0]   absd;
  logic signed [NW-1:0] s_sum;
  logic [NW-1:0]        mag;
  logic [MW:0]          r2;
  logic signed [VW-1:0] qs;
  logic                 is_phase;

  assign stat.out_full = out_valid && !out_ready;

  assign is_phase = (cmd.param == PAR_RX_PHASE) || (cmd.param == PAR_TX_ON_PHASE) ||
                    (cmd.param == PAR_TX_OFF_PHASE);
  assign sc_raw = is_phase ? phase_scale : gain_scale;
  assign sc     = (sc_raw == 16'd0) ? 16'd1 : sc_raw;
  assign e_w    = ENT_W'(32'(param_select) * NUM_POINTS + 32'(point_index));
  assign pt_rd  = (cmd.op == OP_RD_LO) ? lo : hi;
  assign e_rd   = ENT_W'(32'(cmd.param) * NUM_POINTS + 32'(pt_rd));
  assign diff   = 17'(ah) - 17'(al);
  assign absd   = (dd < 0) ? -dd : dd;
  assign s_sum  = NW'(p1) + NW'(p2);
  assign mag    = (n_r < 0) ? NW'(-n_r) : NW'(n_r);
  assign r2     = {rem, sh[QW-1]};
  assign qs     = big ? {1'b0, {QW{1'b1}}} : {1'b0, quo};

  // Bracketing search over the valid points of one parameter
  always_comb begin
    have1 = 1'b0;
    have2 = 1'b0;
    hit   = 1'b0;
    pv_ok = 1'b0;
    vb    = 1'b0;
    h     = '0;
    pv    = '0;
    sv    = '0;
    lv    = '0;
    slv   = '0;
    for (int i = 0; i < NUM_POINTS; i++) begin
      vb = table_vld[ENT_W'(32'(cmd.param) * NUM_POINTS + i)];
      if (vb && !hit && (qf < freq_r[i])) begin
        hit   = 1'b1;
        h     = PT_W'(i);
        pv_ok = have1;
        pv    = lv;
      end
      if (vb) begin
        if (!have1) begin
          have1 = 1'b1;
        end else if (!have2) begin
          have2 = 1'b1;
          sv    = PT_W'(i);
        end
        slv = lv;
        lv  = PT_W'(i);
      end
    end
    if (hit) begin
      if (pv_ok) begin
        lo_sel = pv;
        hi_sel = h;
      end else begin
        lo_sel = h;
        hi_sel = have2 ? sv : h;
      end
    end else begin
      lo_sel = have2 ? slv : lv;
      hi_sel = lv;
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_POINTS; i++) begin
        freq_r[i] <= FREQ_RESET[i];
      end
      phase_scale <= SCALE_RESET;
      gain_scale  <= SCALE_RESET;
    end else if (cfg_valid) begin
      if (32'(cfg_index) < NUM_POINTS) begin
        freq_r[PT_W'(cfg_index)] <= cfg_data;
      end
      if (cfg_index == REG_PHASE_SCALE) begin
        phase_scale <= cfg_data[15:0];
      end
      if (cfg_index == REG_GAIN_SCALE) begin
        gain_scale <= cfg_data[15:0];
      end
    end
  end

  // Table valid marks
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < ENTRIES; i++) begin
        table_vld[i] <= 1'b0;
      end
    end else if (cmd.op == OP_WRITE && 32'(param_select) < NUM_PARAMS &&
                 32'(point_index) < NUM_POINTS) begin
      table_vld[e_w] <= !mark_unset;
    end
  end

  // Table values and working registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_WRITE: begin
        if (32'(param_select) < NUM_PARAMS && 32'(point_index) < NUM_POINTS &&
            !mark_unset) begin
          table_val[e_w] <= cal_value;
        end
      end
      OP_LOAD: begin
        qf <= query_freq;
      end
      OP_SEARCH: begin
        lo   <= lo_sel;
        hi   <= hi_sel;
        none <= !have1;
      end
      OP_RD_LO: begin
        al <= none ? 16'sd0 : table_val[e_rd];
        fl <= none ? 32'd0 : freq_r[lo];
      end
      OP_RD_HI: begin
        ah <= none ? 16'sd0 : table_val[e_rd];
        fh <= none ? 32'd0 : freq_r[hi];
      end
      OP_MUL_A: begin
        dd  <= $signed({1'b0, fh}) - $signed({1'b0, fl});
        dfl <= $signed({1'b0, qf}) - $signed({1'b0, fl});
      end
      OP_MUL_B: begin
        p1 <= 49'(al) * 49'(dd);
      end
      OP_MUL_C: begin
        p2 <= 50'(diff) * 50'(dfl);
      end
      OP_MUL_D: begin
        mden <= (dd == 33'sd0) ? MW'(sc) : MW'(absd[31:0]) * MW'(sc);
      end
      OP_SUM: begin
        if (dd == 33'sd0) begin
          n_r <= NW'(al);
        end else if (dd < 0) begin
          n_r <= -s_sum;
        end else begin
          n_r <= s_sum;
        end
      end
      OP_PREP: begin
        neg <= (n_r < 0);
        big <= (MW'(mag >> INT_BITS) >= mden);
        rem <= MW'(mag >> INT_BITS);
        sh  <= {mag[INT_BITS-1:0], {FRAC_BITS{1'b0}}};
        quo <= '0;
      end
      OP_DIV: begin
        sh <= sh << 1;
        if (r2 >= {1'b0, mden}) begin
          rem <= MW'(r2 - {1'b0, mden});
          quo <= {quo[QW-2:0], 1'b1};
        end else begin
          rem <= r2[MW-1:0];
          quo <= {quo[QW-2:0], 1'b0};
        end
      end
      OP_STORE: begin
        v[cmd.param] <= neg ? -qs : qs;
      end
      default: begin
      end
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.op == OP_EMIT) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_EMIT) begin
      rx_phase_adj     <= sat24(SW'(v[PAR_RX_PHASE]));
      rx_gain_i        <= sat24(ONE - SW'(v[PAR_RX_GAIN]));
      rx_gain_q        <= sat24(ONE + SW'(v[PAR_RX_GAIN]));
      tx_on_phase_adj  <= sat24(SW'(v[PAR_TX_ON_PHASE]));
      tx_off_phase_adj <= sat24(SW'(v[PAR_TX_OFF_PHASE]));
      tx_on_gain_i     <= sat24(ONE + SW'(v[PAR_TX_ON_GAIN]));
      tx_on_gain_q     <= sat24(ONE - SW'(v[PAR_TX_ON_GAIN]));
      tx_off_gain_i    <= sat24(ONE + SW'(v[PAR_TX_OFF_GAIN]));
      tx_off_gain_q    <= sat24(ONE - SW'(v[PAR_TX_OFF_GAIN]));
    end
  end

  `ASSERT_PROP(a_rem_below_divisor, clk, rst, (cmd.op == OP_DIV && !big) |-> (rem < mden))
  `ASSERT_PROP(a_out_from_emit, clk, rst, $rose(out_valid) |-> $past(cmd.op == OP_EMIT))

endmodule

// File: design/iq_calibration_interpolator.sv
`timescale 1ns / 1ps
// Channel   Handshake              Payload
// in        in_valid / in_ready    operation, param_select, point_index, cal_value,
//                                  mark_unset, query_freq
// out       out_valid / out_ready  nine Q(23-FRAC_BITS).FRAC_BITS results, 24 bit signed
// cfg       cfg_valid / cfg_ready  cfg_index, cfg_data
//
// A write request updates the table and gives no result.
// A query request runs the six parameters one after another through one shared
// search, multiply and restoring-divide datapath.
// The divider yields one quotient bit per cycle.
// Reset clears every valid mark and loads the default point frequencies and scales.
// A finished result waits in the output register; the next request is accepted
// while it waits, and a later result stalls only until the register frees up.
module iq_calibration_interpolator import iqci_pkg::*; #(
  parameter int NUM_POINTS = NUM_POINTS_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  // request channel
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic                    operation,
  input  logic [2:0]              param_select,
  input  logic [2:0]              point_index,
  input  logic signed [15:0]      cal_value,
  input  logic                    mark_unset,
  input  logic [31:0]             query_freq,
  // result channel
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [OUT_W-1:0] rx_phase_adj,
  output logic signed [OUT_W-1:0] rx_gain_i,
  output logic signed [OUT_W-1:0] rx_gain_q,
  output logic signed [OUT_W-1:0] tx_on_phase_adj,
  output logic signed [OUT_W-1:0] tx_off_phase_adj,
  output logic signed [OUT_W-1:0] tx_on_gain_i,
  output logic signed [OUT_W-1:0] tx_on_gain_q,
  output logic signed [OUT_W-1:0] tx_off_gain_i,
  output logic signed [OUT_W-1:0] tx_off_gain_q,
  // configuration channel
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [2:0]              cfg_index,
  input  logic [31:0]             cfg_data
);

  cmd_t  cmd;
  stat_t stat;

  // The user must change the registers only while idle; the block does not enforce this and takes every write at once.
  assign cfg_ready = 1'b1;

  // Sequence each request: a write is done on acceptance; a query walks the six parameters, then emits.
  iqci_ctrl #(
    .FRAC_BITS (FRAC_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .operation (operation),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Table, point search, products, divider and the output register.
  iqci_datapath #(
    .NUM_POINTS (NUM_POINTS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_datapath (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .stat             (stat),
    .cfg_valid        (cfg_valid),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .param_select     (param_select),
    .point_index      (point_index),
    .cal_value        (cal_value),
    .mark_unset       (mark_unset),
    .query_freq       (query_freq),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .rx_phase_adj     (rx_phase_adj),
    .rx_gain_i        (rx_gain_i),
    .rx_gain_q        (rx_gain_q),
    .tx_on_phase_adj  (tx_on_phase_adj),
    .tx_off_phase_adj (tx_off_phase_adj),
    .tx_on_gain_i     (tx_on_gain_i),
    .tx_on_gain_q     (tx_on_gain_q),
    .tx_off_gain_i    (tx_off_gain_i),
    .tx_off_gain_q    (tx_off_gain_q)
  );

endmodule
